// File: rtl/assert_macros.svh
// Assertion macros for the velocity slew-rate limiter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VSRL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define VSRL_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define VSRL_ASSERT(label, clk, rst_n, prop, msg)
`define VSRL_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// File: rtl/vsrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vsrl_pkg;

  localparam int unsigned NumCfg = 8;
  localparam int unsigned CfgWidth = 15;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned VelWidth = 16;
  localparam int unsigned TickWidth = 16;

  localparam int unsigned RingSizeDefault = 5;
  localparam int unsigned FeedbackModeDefault = 0;
  localparam int unsigned DefaultIntervalDefault = 2;
  localparam int unsigned MaxTimeoutDefault = 10;

  localparam int unsigned LinMismatch = 200;
  localparam int unsigned TurnMismatch = 2000;

  typedef enum logic [1:0] {
    CMD_VEL  = 2'd0,
    CMD_ODOM = 2'd1,
    CMD_CMDF = 2'd2,
    CMD_TICK = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_LIMIT_X    = 3'd0,
    REG_LIMIT_Y    = 3'd1,
    REG_LIMIT_TURN = 3'd2,
    REG_ACCEL_X    = 3'd3,
    REG_ACCEL_Y    = 3'd4,
    REG_ACCEL_TURN = 3'd5,
    REG_DECEL      = 3'd6,
    REG_SAFE_DECEL = 3'd7
  } reg_e;

  typedef struct packed {
    logic [14:0] limit_x;
    logic [14:0] limit_y;
    logic [14:0] limit_turn;
    logic [14:0] accel_x;
    logic [14:0] accel_y;
    logic [14:0] accel_turn;
    logic [11:0] decel;
    logic [11:0] safe_decel;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/vsrl_median.sv
`timescale 1ns / 1ps
`default_nettype none
// Interval ring and median estimate of the command period. On a command
// request the ring takes the elapsed count and the estimate is updated.
module vsrl_median #(
  parameter int unsigned RingSize = vsrl_pkg::RingSizeDefault,
  parameter int unsigned DefaultInterval = vsrl_pkg::DefaultIntervalDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire logic [vsrl_pkg::TickWidth-1:0] value_i,
  output logic      [vsrl_pkg::TickWidth-1:0] median_o
);
  localparam int unsigned IdxW = $clog2(RingSize);
  localparam int unsigned CntW = $clog2(RingSize + 1);
  localparam int unsigned RankW = $clog2(RingSize + 1);

  logic [vsrl_pkg::TickWidth-1:0] ring_q [RingSize];
  logic [IdxW-1:0] next_q;
  logic [CntW-1:0] count_q, count_d;
  logic [vsrl_pkg::TickWidth-1:0] med_q, med_d;
  logic [vsrl_pkg::TickWidth-1:0] cand [RingSize];
  logic [RingSize-1:0] live;
  logic [RingSize-1:0] hit;

  assign count_d = (count_q < CntW'(RingSize)) ? count_q + CntW'(1) : count_q;

  // The candidate set is the ring after this push, so the median is ready
  // at the next tick without a further pass.
  always_comb begin
    for (int i = 0; i < RingSize; i++) begin
      cand[i] = (IdxW'(i) == next_q) ? value_i : ring_q[i];
      live[i] = (IdxW'(i) == next_q) || (CntW'(i) < count_q);
    end
  end

  // Element i is the median when exactly count/2 live entries order before
  // it, ties by position; until the ring is over half full, the default stands.
  always_comb begin
    logic [RankW-1:0] rank;
    med_d = vsrl_pkg::TickWidth'(DefaultInterval);
    for (int i = 0; i < RingSize; i++) begin
      rank = '0;
      for (int j = 0; j < RingSize; j++) begin
        if (j != i && live[j] &&
            ((cand[j] < cand[i]) || ((cand[j] == cand[i]) && (j < i)))) begin
          rank = rank + RankW'(1);
        end
      end
      hit[i] = live[i] && (rank == RankW'(count_d >> 1));
    end
    for (int i = 0; i < RingSize; i++) begin
      if (hit[i] && (count_d > CntW'(RingSize / 2))) begin
        med_d = cand[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ring_q[next_q] <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q  <= '0;
      count_q <= '0;
      med_q   <= '0;
    end else if (push_i) begin
      next_q  <= (next_q == IdxW'(RingSize - 1)) ? '0 : next_q + IdxW'(1);
      count_q <= count_d;
      med_q   <= med_d;
    end
  end

  assign median_o = med_q;
endmodule
`default_nettype wire

// File: rtl/vsrl_axis.sv
`timescale 1ns / 1ps
`default_nettype none
// One axis of the tick update: countermarch and accel/decel step choice,
// then a move toward the target limited by that step.
module vsrl_axis #(
  parameter int unsigned FeedbackMode = vsrl_pkg::FeedbackModeDefault
) (
  input  wire logic signed [15:0] target_i,
  input  wire logic signed [15:0] last_i,
  input  wire logic signed [15:0] meas_i,
  input  wire logic        [14:0] accel_i,
  input  wire logic        [19:0] decel_i,
  output logic signed      [15:0] res_o
);
  logic signed [16:0] inc;
  logic        [16:0] inc_mag;
  logic        [19:0] step;
  logic               counter;
  logic               accel;
  logic signed [21:0] moved;

  always_comb begin
    inc = 17'(target_i) - 17'(last_i);
    inc_mag = inc[16] ? 17'(-inc) : 17'(inc);
    counter = (FeedbackMode == 1) &&
      ((meas_i > 0 && target_i < 0) || (meas_i < 0 && target_i > 0));
    accel = (inc > 0 && target_i > 0) || (inc < 0 && target_i < 0);
    step = (!counter && accel) ? 20'(accel_i) : decel_i;
    moved = inc[16] ? 22'(last_i) - 22'($signed({1'b0, step}))
                    : 22'(last_i) + 22'($signed({1'b0, step}));
    res_o = (20'(inc_mag) > step) ? moved[15:0] : target_i;
  end
endmodule
`default_nettype wire

// File: rtl/velocity_slew_rate_limiter.sv
`timescale 1ns / 1ps
`default_nettype none
// A tick request's result, if one is emitted, is registered and shown in the cycle after acceptance.
// Throughput: one request per cycle; the input stalls only when the result
// register is full and the output is stalled.
// Reset clears the control state to zero, the elapsed count to all ones and the
// registers to defaults; the interval ring and result data are not cleared.
`include "assert_macros.svh"
module velocity_slew_rate_limiter #(
  parameter int unsigned RING_SIZE = vsrl_pkg::RingSizeDefault,
  parameter int unsigned FEEDBACK_MODE = vsrl_pkg::FeedbackModeDefault,
  parameter int unsigned DEFAULT_INTERVAL_TICKS = vsrl_pkg::DefaultIntervalDefault,
  parameter int unsigned MAX_TIMEOUT_TICKS = vsrl_pkg::MaxTimeoutDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [14:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic signed [15:0] vel_x_i,
  input  wire logic signed [15:0] vel_y_i,
  input  wire logic signed [15:0] vel_turn_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      out_x_o,
  output logic signed [15:0]      out_y_o,
  output logic signed [15:0]      out_turn_o,
  output logic                    feedback_used_o,
  output logic                    input_live_o
);
  vsrl_pkg::cfg_t cfg_q;
  logic signed [15:0] tgt_q [3];
  logic signed [15:0] tgt_d [3];
  logic signed [15:0] last_q [3];
  logic signed [15:0] last_d [3];
  logic signed [15:0] meas_q [3];
  logic signed [15:0] vin [3];
  logic [14:0] lim [3];
  logic [14:0] acc [3];
  logic [19:0] dec [3];
  logic signed [15:0] res [3];
  logic signed [15:0] start [3];
  logic [15:0] ticks_q, ticks_d, elapsed;
  logic [15:0] avg;
  logic active_q, active_d;
  logic accept, is_cmd, is_tick, emit;
  logic timeout, fb_used, differs;
  logic [17:0] lim3;
  logic [18:0] lim5;
  logic [11:0] scale;
  logic [26:0] dprod [3];
  logic signed [16:0] diff [3];
  logic [16:0] dmag [3];
  logic out_valid_q;
  logic signed [15:0] ox_q, oy_q, ot_q;
  logic fb_q, live_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;
  assign is_cmd = accept && (cmd_i == vsrl_pkg::CMD_VEL);
  assign is_tick = accept && (cmd_i == vsrl_pkg::CMD_TICK);

  assign vin[0] = vel_x_i;
  assign vin[1] = vel_y_i;
  assign vin[2] = vel_turn_i;
  assign lim[0] = cfg_q.limit_x;
  assign lim[1] = cfg_q.limit_y;
  assign lim[2] = cfg_q.limit_turn;
  assign acc[0] = cfg_q.accel_x;
  assign acc[1] = cfg_q.accel_y;
  assign acc[2] = cfg_q.accel_turn;

  vsrl_median #(
    .RingSize       (RING_SIZE),
    .DefaultInterval(DEFAULT_INTERVAL_TICKS)
  ) u_median (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (is_cmd),
    .value_i (ticks_q),
    .median_o(avg)
  );

  always_comb begin
    elapsed = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
    lim3 = 18'(avg) * 18'd3;
    if (lim3 > 18'(MAX_TIMEOUT_TICKS)) lim3 = 18'(MAX_TIMEOUT_TICKS);
    lim5 = 19'(avg) * 19'd5;
    timeout = active_q && (avg != '0) && (18'(elapsed) > lim3);
    active_d = active_q && !timeout;
    scale = active_d ? cfg_q.decel : cfg_q.safe_decel;
    for (int a = 0; a < 3; a++) begin
      dprod[a] = 27'(acc[a]) * 27'(scale) + 27'd128;
      dec[a] = {1'b0, dprod[a][26:8]};
      diff[a] = 17'(meas_q[a]) - 17'(last_q[a]);
      dmag[a] = diff[a][16] ? 17'(-diff[a]) : 17'(diff[a]);
    end
    fb_used = (FEEDBACK_MODE != 0) && active_d && (avg != '0) &&
      ((19'(elapsed) > lim5) || (dmag[0] > 17'(vsrl_pkg::LinMismatch)) ||
       (dmag[1] > 17'(vsrl_pkg::LinMismatch)) ||
       (dmag[2] > 17'(vsrl_pkg::TurnMismatch)));
    differs = 1'b0;
    for (int a = 0; a < 3; a++) begin
      start[a] = fb_used ? meas_q[a] : last_q[a];
      if ((timeout ? 16'sd0 : tgt_q[a]) != start[a]) differs = 1'b1;
    end
    emit = differs || active_d;
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    vsrl_axis #(.FeedbackMode(FEEDBACK_MODE)) u_axis (
      .target_i(timeout ? 16'sd0 : tgt_q[a]),
      .last_i  (start[a]),
      .meas_i  (meas_q[a]),
      .accel_i (acc[a]),
      .decel_i (dec[a]),
      .res_o   (res[a])
    );
  end

  always_comb begin
    ticks_d = ticks_q;
    for (int a = 0; a < 3; a++) begin
      tgt_d[a] = tgt_q[a];
      last_d[a] = last_q[a];
    end
    if (is_cmd) begin
      ticks_d = '0;
      for (int a = 0; a < 3; a++) begin
        if (vin[a] > 0) begin
          tgt_d[a] = (vin[a] < $signed({1'b0, lim[a]})) ? vin[a] : $signed({1'b0, lim[a]});
        end else begin
          tgt_d[a] = (vin[a] > -$signed({1'b0, lim[a]})) ? vin[a]
                                                       : -$signed({1'b0, lim[a]});
        end
      end
    end else if (is_tick) begin
      ticks_d = elapsed;
      for (int a = 0; a < 3; a++) begin
        if (timeout) tgt_d[a] = '0;
        last_d[a] = differs ? res[a] : start[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{limit_x: 15'd1000, limit_y: 15'd1000, limit_turn: 15'd1000,
                 accel_x: 15'd50, accel_y: 15'd50, accel_turn: 15'd50,
                 decel: 12'd256, safe_decel: 12'd256};
    end else if (cfg_we_i) begin
      unique case (vsrl_pkg::reg_e'(cfg_idx_i))
        vsrl_pkg::REG_LIMIT_X:    cfg_q.limit_x <= cfg_data_i;
        vsrl_pkg::REG_LIMIT_Y:    cfg_q.limit_y <= cfg_data_i;
        vsrl_pkg::REG_LIMIT_TURN: cfg_q.limit_turn <= cfg_data_i;
        vsrl_pkg::REG_ACCEL_X:    cfg_q.accel_x <= cfg_data_i;
        vsrl_pkg::REG_ACCEL_Y:    cfg_q.accel_y <= cfg_data_i;
        vsrl_pkg::REG_ACCEL_TURN: cfg_q.accel_turn <= cfg_data_i;
        vsrl_pkg::REG_DECEL:      cfg_q.decel <= cfg_data_i[11:0];
        vsrl_pkg::REG_SAFE_DECEL: cfg_q.safe_decel <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= 16'hFFFF;
      active_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        tgt_q[a] <= '0;
        last_q[a] <= '0;
        meas_q[a] <= '0;
      end
    end else begin
      ticks_q <= ticks_d;
      for (int a = 0; a < 3; a++) begin
        tgt_q[a] <= tgt_d[a];
        last_q[a] <= last_d[a];
      end
      if (is_cmd) active_q <= 1'b1;
      else if (is_tick) active_q <= active_d;
      if (accept && (cmd_i != vsrl_pkg::CMD_VEL) && (cmd_i != vsrl_pkg::CMD_TICK) &&
          (32'(cmd_i) == FEEDBACK_MODE)) begin
        for (int a = 0; a < 3; a++) meas_q[a] <= vin[a];
      end
    end
  end

  // Result register: loaded on a tick request that emits, freed when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (is_tick) begin
      out_valid_q <= emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_tick) begin
      ox_q <= differs ? res[0] : start[0];
      oy_q <= differs ? res[1] : start[1];
      ot_q <= differs ? res[2] : start[2];
      fb_q <= fb_used;
      live_q <= active_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o = ox_q;
  assign out_y_o = oy_q;
  assign out_turn_o = ot_q;
  assign feedback_used_o = fb_q;
  assign input_live_o = live_q;

  `VSRL_ASSERT(a_no_emit_non_tick, clk_i, rst_ni,
    (accept && cmd_i != vsrl_pkg::CMD_TICK && !in_stall_o) |=> (!out_valid_o || $past(out_valid_o)),
    "result appeared without a tick")
  `VSRL_ASSERT(a_cmd_clears_ticks, clk_i, rst_ni, is_cmd |=> (ticks_q == '0),
    "elapsed count not cleared by command")
  `VSRL_ASSERT(a_stall_only_full, clk_i, rst_ni, in_stall_o |-> out_valid_o,
    "input stalled with empty result register")
  `VSRL_ASSERT(a_live_matches, clk_i, rst_ni, (out_valid_o && $rose(out_valid_o)) |-> (input_live_o == active_q),
    "reported input state differs from internal state")
endmodule
`default_nettype wire
